[rtl/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg: shared types, tables and functions for the flash record checker
// Holds the expected record table, the name hash table built at elaboration,
// the CRC-16/MODBUS byte step and the item and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

    localparam int HEADER_BYTES      = 24;
    localparam int BLOCK_BYTES_DEF   = 256;
    localparam int NUM_ENTRIES       = 8;
    localparam int NAME_BYTES        = 8;

    localparam logic [2:0]  META_INDEX   = 3'd7;
    localparam logic [31:0] HASH_MULT    = 32'h0000_0083;
    localparam logic [31:0] MAGIC_RESET  = 32'h4550_3130;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Header byte offsets.
    localparam logic [4:0] POS_STATE_LO = 5'd16;
    localparam logic [4:0] POS_STATE_HI = 5'd17;
    localparam logic [4:0] POS_FLAGS_LO = 5'd18;
    localparam logic [4:0] POS_FLAGS_HI = 5'd19;
    localparam logic [4:0] POS_LEN_LO   = 5'd20;
    localparam logic [4:0] POS_LEN_HI   = 5'd21;
    localparam logic [4:0] POS_CRC_LO   = 5'd22;
    localparam logic [4:0] POS_CRC_HI   = 5'd23;

    localparam logic [7:0] ENTRY_NAMES [NUM_ENTRIES][NAME_BYTES] = '{
        '{"d", "e", "v", "_", "i", "n", "f", "o"},
        '{"b", "l", "e", "_", "m", "u", "l", "t"},
        '{"h", "e", "a", "l", "t", "h", 8'h00, 8'h00},
        '{"h", "s", "y", "n", "c", 8'h00, 8'h00, 8'h00},
        '{"p", "o", "w", "e", "r", 8'h00, 8'h00, 8'h00},
        '{"n", "v", "_", "r", "1", 8'h00, 8'h00, 8'h00},
        '{"r", "_", "s", "i", "z", "e", 8'h00, 8'h00},
        '{"r", "1", "_", "m", "e", "t", "a", 8'h00}
    };

    localparam logic [15:0] ENTRY_LENGTHS [NUM_ENTRIES] = '{
        16'd52, 16'd90, 16'd12, 16'd24, 16'd4, 16'd124, 16'd1, 16'd8
    };

    typedef logic [NUM_ENTRIES-1:0][31:0] hash_table_t;

    // Name hash h = h * 131 + byte over the eight name bytes, one per entry.
    function automatic hash_table_t build_hash_table();
        hash_table_t tab;
        logic [31:0] h;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            h = 32'h0;
            for (int i = 0; i < NAME_BYTES; i++)
            begin
                h = 32'(h * HASH_MULT) + {24'h0, ENTRY_NAMES[k][i]};
            end
            tab[k] = h;
        end
        return tab;
    endfunction

    localparam hash_table_t NAME_HASH = build_hash_table();

    // One byte of CRC-16/MODBUS, reflected, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    typedef struct packed {
        logic [2:0] record_index;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        record_ok;
        logic [15:0] record_state;
        logic        keep_flag;
        logic [31:0] generation;
        logic        generation_ok;
    } result_t;

endpackage

`default_nettype wire

[rtl/frc_core.sv]
// ----------------------------------------------------------------------------
// frc_core: per-record check state and the single-byte update logic
// Compares header bytes, runs the payload CRC, captures the state, keep and
// meta words, and forms the result for a byte that ends a record.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_core
    import frc_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    localparam int POS_W      = $clog2(BLOCK_BYTES + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire item_t       item,
    input  wire logic [31:0] magic,
    output result_t          result
);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             hmatch_reg,   hmatch_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [15:0]      scrc_reg,     scrc_next;
    logic [15:0]      state_reg,    state_next;
    logic             keep_reg,     keep_next;
    logic [31:0]      gen_reg,      gen_next;
    logic [31:0]      comp_reg,     comp_next;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] off;
    logic [4:0]       hpos;
    logic [2:0]       name_sel;
    logic [15:0]      len;
    logic [7:0]       b;
    logic             byte_ok;
    logic             complete;
    logic             ok;
    logic             meta_ok;

    always_comb
    begin
        b   = item.data_byte;
        len = ENTRY_LENGTHS[item.record_index];

        // A first byte starts from the cleared record state.
        if (item.first_byte)
        begin
            pos         = '0;
            hmatch_next = 1'b1;
            crc_next    = CRC_INIT;
            scrc_next   = 16'h0;
            state_next  = 16'h0;
            keep_next   = 1'b0;
            gen_next    = 32'h0;
            comp_next   = 32'h0;
        end
        else
        begin
            pos         = pos_reg;
            hmatch_next = hmatch_reg;
            crc_next    = crc_reg;
            scrc_next   = scrc_reg;
            state_next  = state_reg;
            keep_next   = keep_reg;
            gen_next    = gen_reg;
            comp_next   = comp_reg;
        end

        hpos     = pos[4:0];
        name_sel = hpos[2:0] - 3'd4;
        off      = pos - POS_W'(HEADER_BYTES);
        byte_ok  = 1'b1;

        if (pos < POS_W'(HEADER_BYTES))
        begin
            case (hpos) inside
                [5'd0:5'd3]:   byte_ok = (b == NAME_HASH[item.record_index][8*hpos[1:0] +: 8]);
                [5'd4:5'd11]:  byte_ok = (b == ENTRY_NAMES[item.record_index][name_sel]);
                [5'd12:5'd15]: byte_ok = (b == magic[8*hpos[1:0] +: 8]);
                POS_FLAGS_LO:  byte_ok = (b[7:2] == {3'b000, item.record_index});
                POS_FLAGS_HI:  byte_ok = (b == 8'h00);
                POS_LEN_LO:    byte_ok = (b == len[7:0]);
                POS_LEN_HI:    byte_ok = (b == len[15:8]);
                default:       byte_ok = 1'b1;
            endcase
            if (!byte_ok)
                hmatch_next = 1'b0;

            case (hpos)
                POS_STATE_LO: state_next[7:0]  = b;
                POS_STATE_HI: state_next[15:8] = b;
                POS_FLAGS_LO: keep_next        = b[1];
                POS_CRC_LO:   scrc_next[7:0]   = b;
                POS_CRC_HI:   scrc_next[15:8]  = b;
                default:      ;
            endcase
        end
        else if (pos < POS_W'(BLOCK_BYTES))
        begin
            if (16'(off) < len)
                crc_next = crc_byte(crc_next, b);
            if (off < POS_W'(4))
                gen_next[8*off[1:0] +: 8] = b;
            else if (off < POS_W'(8))
                comp_next[8*off[1:0] +: 8] = b;
        end

        complete = (pos < POS_W'(BLOCK_BYTES)) &&
                   ((17'(pos) + 17'd1) >= (17'(HEADER_BYTES) + 17'(len)));
        ok       = hmatch_next && complete && (crc_next == scrc_next);
        meta_ok  = ok && (item.record_index == META_INDEX);

        result.record_ok     = ok;
        result.record_state  = state_next;
        result.keep_flag     = keep_next;
        result.generation    = meta_ok ? gen_next : 32'h0;
        result.generation_ok = meta_ok && (comp_next == ~gen_next);

        pos_next = (pos < POS_W'(BLOCK_BYTES)) ? pos + POS_W'(1) : POS_W'(BLOCK_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hmatch_reg <= 1'b1;
            crc_reg    <= CRC_INIT;
            scrc_reg   <= 16'h0;
            state_reg  <= 16'h0;
            keep_reg   <= 1'b0;
            gen_reg    <= 32'h0;
            comp_reg   <= 32'h0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                // The record is finished; clear for the next one.
                pos_reg    <= '0;
                hmatch_reg <= 1'b1;
                crc_reg    <= CRC_INIT;
                scrc_reg   <= 16'h0;
                state_reg  <= 16'h0;
                keep_reg   <= 1'b0;
                gen_reg    <= 32'h0;
                comp_reg   <= 32'h0;
            end
            else
            begin
                pos_reg    <= pos_next;
                hmatch_reg <= hmatch_next;
                crc_reg    <= crc_next;
                scrc_reg   <= scrc_next;
                state_reg  <= state_next;
                keep_reg   <= keep_next;
                gen_reg    <= gen_next;
                comp_reg   <= comp_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/flash_record_checker.sv]
// An accepted byte is held in the input register and passes the check stage,
// which loads the result of a last byte into the result register.
// Throughput: one byte per cycle, set by the byte-wide CRC and compare stage; a
// last byte stalls the input only while the previous result is still unaccepted.
// Reset: rst_n clears the pipeline valids and record state asynchronously and
// restores the partition magic to its default.
// ----------------------------------------------------------------------------
// flash_record_checker: byte-stream checker for stored flash records
// Checks the 24-byte header of each record against the built-in record table
// and the partition magic, runs CRC-16/MODBUS over the expected payload, and
// sends one result transaction on the last byte of every record.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_record_checker
    import frc_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write channel: partition magic.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,

    // Record byte stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [3:0]  s_axis_tuser,   // [2:0] record_index, [3] first_byte
    input  wire logic        s_axis_tlast,   // last_byte

    // Result stream, one transaction per record.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [0] record_ok, [16:1] record_state,
                                             // [17] keep_flag, [49:18] generation,
                                             // [50] generation_ok, [55:51] zero
    output logic             m_axis_tlast
);

    logic [31:0] magic_reg;

    logic        in_valid_reg;
    item_t       in_item_reg;

    logic        out_valid_reg;
    result_t     out_data_reg;

    logic        out_free;
    logic        advance;
    result_t     core_result;

    // The partition magic should be rewritten only while no record is in flight; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= MAGIC_RESET;
        else if (cfg_valid)
            magic_reg <= cfg_data;
    end

    // The held byte moves through the check stage unless it ends a record
    // and the result register still holds a result that is not being taken.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.record_index <= s_axis_tuser[2:0];
            in_item_reg.data_byte    <= s_axis_tdata;
            in_item_reg.first_byte   <= s_axis_tuser[3];
            in_item_reg.last_byte    <= s_axis_tlast;
        end
    end

    frc_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .magic  (magic_reg),
        .result (core_result)
    );

    // Result register: loaded when a record's last byte passes the check stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_item_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
            out_data_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = 1'b1;
    assign m_axis_tdata  = {5'b00000,
                            out_data_reg.generation_ok,
                            out_data_reg.generation,
                            out_data_reg.keep_flag,
                            out_data_reg.record_state,
                            out_data_reg.record_ok};

endmodule

`default_nettype wire

[test/tb_flash_record_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flash_record_checker: self-checking bench for the flash record checker
// Streams whole flash records, one byte per transaction, into the checker and
// predicts each record verdict with an independent model of the header table,
// name hash and CRC-16/MODBUS. Directed records cover every table entry, the
// size limits and hash, flags and length mismatches. Random records mix well-formed
// records with damaged records and noise, under several partition magics.
// ----------------------------------------------------------------------------

module tb_flash_record_checker;

    localparam int HDR_LEN        = 24;
    localparam int BLOCK_LEN      = 256;
    localparam int WORD_BYTES     = 4;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    // Header layout, byte offsets from the start of a record.
    localparam int OFS_NAME     = 4;
    localparam int OFS_MAGIC    = 12;
    localparam int OFS_STATE_LO = 16;
    localparam int OFS_STATE_HI = 17;
    localparam int OFS_FLAGS_LO = 18;
    localparam int OFS_FLAGS_HI = 19;
    localparam int OFS_LEN_LO   = 20;
    localparam int OFS_LEN_HI   = 21;
    localparam int OFS_CRC_LO   = 22;
    localparam int OFS_CRC_HI   = 23;

    localparam logic [2:0]  META_SLOT     = 3'd7;
    localparam logic [31:0] HASH_FACTOR   = 32'd131;
    localparam logic [31:0] MAGIC_DEFAULT = 32'h4550_3130;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_REFLECTED = 16'hA001;

    localparam logic [7:0] REC_NAME [8][8] = '{
        '{"d", "e", "v", "_", "i", "n", "f", "o"},
        '{"b", "l", "e", "_", "m", "u", "l", "t"},
        '{"h", "e", "a", "l", "t", "h", 8'h00, 8'h00},
        '{"h", "s", "y", "n", "c", 8'h00, 8'h00, 8'h00},
        '{"p", "o", "w", "e", "r", 8'h00, 8'h00, 8'h00},
        '{"n", "v", "_", "r", "1", 8'h00, 8'h00, 8'h00},
        '{"r", "_", "s", "i", "z", "e", 8'h00, 8'h00},
        '{"r", "1", "_", "m", "e", "t", "a", 8'h00}
    };

    localparam logic [15:0] REC_LEN [8] = '{
        16'd52, 16'd90, 16'd12, 16'd24, 16'd4, 16'd124, 16'd1, 16'd8
    };

    typedef enum int {
        FLIP_BIT,
        TRUNCATE,
        EXTEND,
        MIXED_INDEX,
        RESTART,
        SPLIT
    } damage_t;

    typedef struct {
        logic [2:0] slot;
        logic [7:0] value;
        bit         first;
        bit         last;
    } rec_item_t;

    typedef struct {
        bit          ok;
        logic [15:0] state;
        bit          keep;
        logic [31:0] gen;
        bit          gen_ok;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [3:0]  s_axis_tuser = 4'h0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Predicted checker state.
    logic [31:0] magic_reg;
    logic [8:0]  rec_pos;
    bit          hdr_ok;
    logic [15:0] run_crc;
    logic [15:0] hdr_crc;
    logic [15:0] cap_state;
    bit          cap_keep;
    logic [31:0] gen_word;
    logic [31:0] cpl_word;

    verdict_t    pending_verdicts[$];
    verdict_t    due;
    rec_item_t   rec_items[$];

    int          error_count = 0;
    int          bytes_sent = 0;
    int          predicted_results = 0;
    int          idle_cycles = 0;
    int          rx_stall = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    flash_record_checker u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] name_hash(input logic [2:0] idx);
        logic [31:0] h;
        h = 32'h0;
        for (int i = 0; i < 8; i++)
        begin
            h = h * HASH_FACTOR + {24'h0, REC_NAME[idx][i]};
        end
        return h;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_REFLECTED) : (r >> 1);
        end
        return r;
    endfunction

    // State, CRC bytes and bits 1 and 0 of the flags are never compared.
    function automatic bit header_byte_matches(input logic [2:0] idx, input int p,
                                               input logic [7:0] b);
        logic [31:0] h;
        logic [15:0] len;
        h = name_hash(idx);
        len = REC_LEN[idx];
        if (p < OFS_NAME)
            return b == h[8 * p +: 8];
        if (p < OFS_MAGIC)
            return b == REC_NAME[idx][p - OFS_NAME];
        if (p < OFS_STATE_LO)
            return b == magic_reg[8 * (p - OFS_MAGIC) +: 8];
        case (p)
            OFS_FLAGS_LO: return b[7:2] == {3'b000, idx};
            OFS_FLAGS_HI: return b == 8'h00;
            OFS_LEN_LO:   return b == len[7:0];
            OFS_LEN_HI:   return b == len[15:8];
            default:      return 1'b1;
        endcase
    endfunction

    function automatic void clear_record();
        rec_pos = 9'd0;
        hdr_ok = 1'b1;
        run_crc = CRC_SEED;
        hdr_crc = 16'h0;
        cap_state = 16'h0;
        cap_keep = 1'b0;
        gen_word = 32'h0;
        cpl_word = 32'h0;
    endfunction

    // Follows one accepted byte through the checker and queues the verdict
    // when the byte closes a record.
    task automatic track_record_byte(input rec_item_t it);
        int       p;
        int       off;
        int       len;
        bit       ok;
        verdict_t v;
        len = REC_LEN[it.slot];
        if (it.first)
            clear_record();
        p = int'(rec_pos);
        if (p < HDR_LEN)
        begin
            if (!header_byte_matches(it.slot, p, it.value))
                hdr_ok = 1'b0;
            case (p)
                OFS_STATE_LO: cap_state[7:0] = it.value;
                OFS_STATE_HI: cap_state[15:8] = it.value;
                OFS_FLAGS_LO: cap_keep = it.value[1];
                OFS_CRC_LO:   hdr_crc[7:0] = it.value;
                OFS_CRC_HI:   hdr_crc[15:8] = it.value;
                default: ;
            endcase
        end
        else if (p < BLOCK_LEN)
        begin
            off = p - HDR_LEN;
            if (off < len)
                run_crc = crc_step(run_crc, it.value);
            if (off < WORD_BYTES)
                gen_word[8 * off +: 8] = it.value;
            else if (off < 2 * WORD_BYTES)
                cpl_word[8 * (off - WORD_BYTES) +: 8] = it.value;
        end
        if (!it.last)
        begin
            // The position saturates one past the block.
            if (p < BLOCK_LEN)
                rec_pos = rec_pos + 9'd1;
        end
        else
        begin
            ok = hdr_ok && p < BLOCK_LEN && p + 1 >= HDR_LEN + len && run_crc == hdr_crc;
            v.ok = ok;
            v.state = cap_state;
            v.keep = cap_keep;
            v.gen = (ok && it.slot == META_SLOT) ? gen_word : 32'h0;
            v.gen_ok = ok && it.slot == META_SLOT && cpl_word == ~gen_word;
            pending_verdicts.push_back(v);
            predicted_results++;
            clear_record();
        end
    endtask

    // Builds a well-formed record for one table entry into rec_items.
    function automatic void build_record(input logic [2:0] idx, input logic [31:0] magic,
                                         input logic [15:0] st, input bit keep,
                                         input logic [31:0] gen, input bit cpl_good);
        logic [31:0] h;
        logic [15:0] len;
        logic [15:0] c;
        logic [7:0]  hdr [HDR_LEN];
        logic [7:0]  pl[$];
        rec_item_t   it;
        h = name_hash(idx);
        len = REC_LEN[idx];
        rec_items.delete();
        for (int k = 0; k < len; k++)
        begin
            pl.push_back(8'($urandom));
        end
        if (idx == META_SLOT)
        begin
            for (int k = 0; k < WORD_BYTES; k++)
            begin
                pl[k] = gen[8 * k +: 8];
                if (cpl_good)
                    pl[k + WORD_BYTES] = ~gen[8 * k +: 8];
            end
        end
        c = CRC_SEED;
        foreach (pl[k])
        begin
            c = crc_step(c, pl[k]);
        end
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            hdr[k] = h[8 * k +: 8];
            hdr[OFS_MAGIC + k] = magic[8 * k +: 8];
        end
        for (int k = 0; k < 8; k++)
        begin
            hdr[OFS_NAME + k] = REC_NAME[idx][k];
        end
        hdr[OFS_STATE_LO] = st[7:0];
        hdr[OFS_STATE_HI] = st[15:8];
        hdr[OFS_FLAGS_LO] = {3'b000, idx, keep, 1'($urandom)};
        hdr[OFS_FLAGS_HI] = 8'h00;
        hdr[OFS_LEN_LO] = len[7:0];
        hdr[OFS_LEN_HI] = len[15:8];
        hdr[OFS_CRC_LO] = c[7:0];
        hdr[OFS_CRC_HI] = c[15:8];
        it.slot = idx;
        it.first = 1'b0;
        it.last = 1'b0;
        for (int k = 0; k < HDR_LEN; k++)
        begin
            it.value = hdr[k];
            rec_items.push_back(it);
        end
        foreach (pl[k])
        begin
            it.value = pl[k];
            rec_items.push_back(it);
        end
        rec_items[0].first = 1'b1;
        rec_items[$].last = 1'b1;
    endfunction

    // Grows the staged record with random bytes to n bytes in all.
    function automatic void pad_record(input int n);
        rec_item_t it;
        it = rec_items[$];
        it.first = 1'b0;
        it.last = 1'b0;
        rec_items[$].last = 1'b0;
        while (rec_items.size() < n)
        begin
            it.value = 8'($urandom);
            rec_items.push_back(it);
        end
        rec_items[$].last = 1'b1;
    endfunction

    function automatic void damage_record(input damage_t d);
        int p;
        int q;
        case (d)
            FLIP_BIT:
            begin
                p = $urandom_range(0, rec_items.size() - 1);
                rec_items[p].value = rec_items[p].value ^ (8'h01 << $urandom_range(0, 7));
            end
            TRUNCATE:
            begin
                p = $urandom_range(1, rec_items.size() - 1);
                while (rec_items.size() > p)
                    void'(rec_items.pop_back());
                rec_items[$].last = 1'b1;
            end
            EXTEND:
            begin
                // Rarely run up to or past the end of the block.
                if ($urandom_range(0, 15) == 0)
                    pad_record(BLOCK_LEN - 2 + $urandom_range(0, 4));
                else
                    pad_record(rec_items.size() + $urandom_range(1, 20));
            end
            MIXED_INDEX:
            begin
                p = $urandom_range(0, rec_items.size() - 1);
                q = $urandom_range(p, p + 8);
                for (int k = p; k <= q && k < rec_items.size(); k++)
                    rec_items[k].slot = 3'($urandom);
            end
            RESTART:
            begin
                p = $urandom_range(1, rec_items.size() - 1);
                rec_items[p].first = 1'b1;
            end
            SPLIT:
            begin
                // The tail then forms a record of its own without a first byte.
                p = $urandom_range(0, rec_items.size() - 2);
                rec_items[p].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Drives one byte transaction and waits until the checker takes it.
    task automatic send_item(input rec_item_t it);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = it.value;
        s_axis_tuser = {it.first, it.slot};
        s_axis_tlast = it.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_record_byte(it);
        bytes_sent++;
    endtask

    task automatic send_record();
        foreach (rec_items[k])
            send_item(rec_items[k]);
    endtask

    task automatic send_good(input logic [2:0] idx);
        build_record(idx, magic_reg, 16'($urandom), 1'($urandom), pick_word(),
                     $urandom_range(0, 4) != 0);
        send_record();
    endtask

    // Stops the stream and lets every predicted verdict come out, then lets
    // bytes that close no record settle.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        magic_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    // Every table entry, both ends of the state word, the meta record with a
    // good and a bad complement, and the size and header field corner cases.
    task automatic test_directed_records();
        rec_item_t it;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        build_record(3'd0, magic_reg, 16'h0000, 1'b0, 32'h0, 1'b1);
        send_record();
        build_record(3'd1, magic_reg, 16'hFFFF, 1'b1, 32'h0, 1'b1);
        send_record();
        for (int k = 2; k < 7; k++)
            send_good(3'(k));
        build_record(META_SLOT, magic_reg, 16'hA55A, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_record();
        build_record(META_SLOT, magic_reg, 16'h0001, 1'b1, $urandom, 1'b0);
        send_record();

        // A record of a single byte.
        rec_items.delete();
        it.slot = 3'd6;
        it.value = 8'hFF;
        it.first = 1'b1;
        it.last = 1'b1;
        rec_items.push_back(it);
        send_record();

        // Header without its payload.
        build_record(3'd0, magic_reg, 16'h1234, 1'b1, 32'h0, 1'b1);
        while (rec_items.size() > HDR_LEN)
            void'(rec_items.pop_back());
        rec_items[$].last = 1'b1;
        send_record();

        // Exactly a full block passes, one byte more fails.
        build_record(3'd4, magic_reg, 16'h8001, 1'b1, 32'h0, 1'b1);
        pad_record(BLOCK_LEN);
        send_record();
        build_record(3'd4, magic_reg, 16'h8001, 1'b1, 32'h0, 1'b1);
        pad_record(BLOCK_LEN + 1);
        send_record();

        // Payload CRC, upper flags byte, length and hash mismatches.
        build_record(3'd6, magic_reg, 16'h0F0F, 1'b0, 32'h0, 1'b1);
        rec_items[HDR_LEN].value = rec_items[HDR_LEN].value ^ 8'h80;
        send_record();
        build_record(3'd6, magic_reg, 16'h00FF, 1'b1, 32'h0, 1'b1);
        rec_items[OFS_FLAGS_HI].value = 8'h01;
        send_record();
        build_record(3'd4, magic_reg, 16'hFF00, 1'b0, 32'h0, 1'b1);
        rec_items[OFS_LEN_LO].value = rec_items[OFS_LEN_LO].value ^ 8'h01;
        send_record();
        build_record(3'd6, magic_reg, 16'h7FFF, 1'b1, 32'h0, 1'b1);
        rec_items[0].value = rec_items[0].value ^ 8'h01;
        send_record();

        // A header byte tagged with another index, and a restart mid-record.
        build_record(3'd4, magic_reg, 16'h4321, 1'b1, 32'h0, 1'b1);
        rec_items[OFS_NAME + 4].slot = 3'd2;
        send_record();
        build_record(3'd6, magic_reg, 16'h2468, 1'b0, 32'h0, 1'b1);
        rec_items[OFS_MAGIC].first = 1'b1;
        send_record();
    endtask

    // Each magic value, the extremes among them; records built with the
    // previous magic must fail.
    task automatic test_partition_magic();
        logic [31:0] values [4];
        logic [31:0] prev;
        values = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, MAGIC_DEFAULT};
        foreach (values[v])
        begin
            prev = magic_reg;
            write_magic(values[v]);
            send_good(META_SLOT);
            build_record(3'd6, prev, 16'($urandom), 1'($urandom), pick_word(), 1'b1);
            send_record();
        end
    endtask

    // The sender holds off until the checker has answered everything.
    task automatic test_drain_pause();
        repeat (2)
        begin
            send_good(3'd6);
            wait_idle();
        end
    endtask

    task automatic test_random_records();
        int        phase_bytes;
        int        sel;
        int        n;
        rec_item_t it;
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase != 0)
                write_magic(pick_word());
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < 30)
            begin
                // Some records go through with no idling on one side or both.
                tx_idle_en = $urandom_range(0, 3) != 0;
                rx_idle_en = $urandom_range(0, 3) != 0;
                sel = $urandom_range(0, 9);
                if (sel < 6)
                begin
                    send_good(3'($urandom));
                end
                else if (sel == 6)
                begin
                    rec_items.delete();
                    n = $urandom_range(1, 30);
                    repeat (n)
                    begin
                        it.slot = 3'($urandom);
                        it.value = 8'($urandom);
                        it.first = $urandom_range(0, 7) == 0;
                        it.last = $urandom_range(0, 7) == 0;
                        rec_items.push_back(it);
                    end
                    rec_items[$].last = 1'b1;
                    send_record();
                end
                else if (sel == 7)
                begin
                    build_record(3'($urandom), $urandom, 16'($urandom), 1'($urandom),
                                 pick_word(), 1'b1);
                    send_record();
                end
                else
                begin
                    build_record(3'($urandom), magic_reg, 16'($urandom), 1'($urandom),
                                 pick_word(), 1'b1);
                    damage_record(damage_t'($urandom_range(FLIP_BIT, SPLIT)));
                    send_record();
                end
            end
        end
    endtask

    // Result side: random back-pressure.
    always @(negedge clk)
    begin
        if (rx_stall == 0 && rx_idle_en)
            rx_stall = pick_gap();
        if (rx_stall != 0)
        begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready = 1'b1;
        end
    end

    // Compares every result transaction with the oldest predicted verdict.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("unexpected result", {8'h0, m_axis_tdata[23:0]}, 32'h0);
            end
            else
            begin
                due = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== due.ok)
                    report_mismatch("record_ok", m_axis_tdata[0], due.ok);
                if (m_axis_tdata[16:1] !== due.state)
                    report_mismatch("record_state", m_axis_tdata[16:1], due.state);
                if (m_axis_tdata[17] !== due.keep)
                    report_mismatch("keep_flag", m_axis_tdata[17], due.keep);
                if (m_axis_tdata[49:18] !== due.gen)
                    report_mismatch("generation", m_axis_tdata[49:18], due.gen);
                if (m_axis_tdata[50] !== due.gen_ok)
                    report_mismatch("generation_ok", m_axis_tdata[50], due.gen_ok);
            end
        end
    end

    // Ends a run that stops making progress on every channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        magic_reg = MAGIC_DEFAULT;
        clear_record();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_records();
        test_partition_magic();
        test_drain_pause();
        test_random_records();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/frc_pkg.sv
rtl/frc_core.sv
rtl/flash_record_checker.sv
test/tb_flash_record_checker.sv
